@@ hdl/gbs_pkg.sv @@
// gbs_pkg: shared constants, types and state encodings for the greedy box
// suppression unit. Depends on nothing; imported by every module in hdl/ but gbs_ram.
`default_nettype none

package gbs_pkg;

  // sizing
  localparam int unsigned MAX_BOXES       = 1024;
  localparam int unsigned MAX_KEEP        = 64;
  localparam int unsigned COORD_FRAC_BITS = 4;

  localparam int unsigned ADDR_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_BOXES + 1);
  localparam int unsigned KADDR_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // fixed field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned BOX_W   = 4 * COORD_W;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned KLIM_W  = 7;
  localparam int unsigned KIDX_W  = 10;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned OUT_W   = KIDX_W + RANK_W;

  // arithmetic widths
  localparam int unsigned ONE     = 1 << COORD_FRAC_BITS;
  localparam int unsigned DIM_W   = COORD_W + 2;      // signed extent
  localparam int unsigned WC_W    = DIM_W - 1;        // clamped extent
  localparam int unsigned AREA_W  = 34;
  localparam int unsigned INTER_W = 2 * WC_W;
  localparam int unsigned UNI_W   = AREA_W + 2;
  localparam int unsigned MA_W    = WC_W;
  localparam int unsigned MB_W    = AREA_W;
  localparam int unsigned PROD_W  = MA_W + MB_W;
  localparam int unsigned ENTRY_W = AREA_W + BOX_W;

  localparam logic signed [DIM_W-1:0] ONE_S = DIM_W'(ONE);

  // configuration
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT    = CFG_IDX_W'(1);
  localparam logic [THR_W-1:0]     THR_RESET         = THR_W'(45875);
  localparam logic [KLIM_W-1:0]    KEEP_RESET        = KLIM_W'(64);
  localparam logic [KLIM_W-1:0]    KEEP_MAX          = KLIM_W'(MAX_KEEP);

  // box field offsets
  localparam int unsigned X1_LO = 0;
  localparam int unsigned Y1_LO = COORD_W;
  localparam int unsigned X2_LO = 2 * COORD_W;
  localparam int unsigned Y2_LO = 3 * COORD_W;

  // loader to store write
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic [BOX_W-1:0]         box;
    logic signed [AREA_W-1:0] area;
  } ld_wr_t;

  // pair test result
  typedef struct packed {
    logic done;
    logic suppress;
  } pair_res_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_OUTER,
    S_IREAD,
    S_JREQ,
    S_JREAD,
    S_TEST,
    S_EREQ,
    S_ERD
  } seq_state_e;

  typedef enum logic [2:0] {
    P_IDLE,
    P_MUL1,
    P_UNION,
    P_MUL2,
    P_CMP
  } pair_state_e;

endpackage

`default_nettype wire

@@ hdl/gbs_ram.sv @@
// gbs_ram: generic single-write, single-read memory with registered read data.
// Depends on nothing.
`default_nettype none

module gbs_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/gbs_loader.sv @@
// gbs_loader: input stage that registers each box and computes its signed
// inclusive area for the box store. Depends on gbs_pkg.
`default_nettype none

module gbs_loader (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [gbs_pkg::BOX_W-1:0]     box_i,
  input  wire logic [gbs_pkg::ADDR_W-1:0]    addr_i,
  input  wire logic                          full_i,
  output gbs_pkg::ld_wr_t                    wr_o
);
  import gbs_pkg::*;

  logic                    we_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [BOX_W-1:0]        box_q;
  logic signed [DIM_W-1:0] dx;
  logic signed [DIM_W-1:0] dy;
  logic signed [2*DIM_W-1:0] prod;

  // write strobe, dropped once the store is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      we_q <= 1'b0;
    end else begin
      we_q <= accept_i && !full_i;
    end
  end

  // box payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      addr_q <= addr_i;
      box_q  <= box_i;
    end
  end

  // inclusive extents, may go negative for inverted boxes
  always_comb begin
    dx   = $signed({2'b00, box_q[X2_LO +: COORD_W]})
         - $signed({2'b00, box_q[X1_LO +: COORD_W]}) + ONE_S;
    dy   = $signed({2'b00, box_q[Y2_LO +: COORD_W]})
         - $signed({2'b00, box_q[Y1_LO +: COORD_W]}) + ONE_S;
    prod = dx * dy;
  end

  assign wr_o.we   = we_q;
  assign wr_o.addr = addr_q;
  assign wr_o.box  = box_q;
  assign wr_o.area = prod[AREA_W-1:0];

endmodule

`default_nettype wire

@@ hdl/gbs_pair_unit.sv @@
// gbs_pair_unit: overlap test of one kept box against one later box, using a
// single shared multiplier for intersection and threshold products.
// Depends on gbs_pkg.
`default_nettype none

module gbs_pair_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [gbs_pkg::BOX_W-1:0]       box_a_i,
  input  wire logic signed [gbs_pkg::AREA_W-1:0] area_a_i,
  input  wire logic [gbs_pkg::BOX_W-1:0]       box_b_i,
  input  wire logic signed [gbs_pkg::AREA_W-1:0] area_b_i,
  input  wire logic [gbs_pkg::THR_W-1:0]       thr_i,
  output gbs_pkg::pair_res_t                   res_o
);
  import gbs_pkg::*;

  pair_state_e state_q, state_d;

  logic [WC_W-1:0]          w_q, h_q;
  logic signed [UNI_W-1:0]  sum_q;
  logic [PROD_W-1:0]        prod_q;
  logic [INTER_W-1:0]       inter_q;
  logic [MB_W-1:0]          uni_q;
  logic                     nonpos_q;

  logic [COORD_W-1:0]       lo_x, hi_x, lo_y, hi_y;
  logic signed [DIM_W-1:0]  w_raw, h_raw;
  logic [WC_W-1:0]          w_clamp, h_clamp;
  logic [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic signed [UNI_W-1:0]  uni;

  // overlap extents, empty overlap clamps to zero
  always_comb begin
    hi_x = (box_a_i[X1_LO +: COORD_W] > box_b_i[X1_LO +: COORD_W]) ?
           box_a_i[X1_LO +: COORD_W] : box_b_i[X1_LO +: COORD_W];
    hi_y = (box_a_i[Y1_LO +: COORD_W] > box_b_i[Y1_LO +: COORD_W]) ?
           box_a_i[Y1_LO +: COORD_W] : box_b_i[Y1_LO +: COORD_W];
    lo_x = (box_a_i[X2_LO +: COORD_W] < box_b_i[X2_LO +: COORD_W]) ?
           box_a_i[X2_LO +: COORD_W] : box_b_i[X2_LO +: COORD_W];
    lo_y = (box_a_i[Y2_LO +: COORD_W] < box_b_i[Y2_LO +: COORD_W]) ?
           box_a_i[Y2_LO +: COORD_W] : box_b_i[Y2_LO +: COORD_W];
    w_raw   = $signed({2'b00, lo_x}) - $signed({2'b00, hi_x}) + ONE_S;
    h_raw   = $signed({2'b00, lo_y}) - $signed({2'b00, hi_y}) + ONE_S;
    w_clamp = w_raw[DIM_W-1] ? '0 : w_raw[WC_W-1:0];
    h_clamp = h_raw[DIM_W-1] ? '0 : h_raw[WC_W-1:0];
  end

  // shared multiplier: width times height, then threshold times union
  always_comb begin
    if (state_q == P_MUL2) begin
      mul_a = MA_W'(thr_i);
      mul_b = uni_q;
    end else begin
      mul_a = w_q;
      mul_b = MB_W'(h_q);
    end
    mul_p = mul_a * mul_b;
  end

  assign uni = sum_q - $signed({{(UNI_W-INTER_W){1'b0}}, prod_q[INTER_W-1:0]});

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      P_IDLE:  if (start_i) state_d = P_MUL1;
      P_MUL1:  state_d = P_UNION;
      P_UNION: state_d = P_MUL2;
      P_MUL2:  state_d = P_CMP;
      P_CMP:   state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        if (start_i) begin
          w_q   <= w_clamp;
          h_q   <= h_clamp;
          sum_q <= UNI_W'(area_a_i) + UNI_W'(area_b_i);
        end
      end
      P_MUL1: prod_q <= mul_p;
      P_UNION: begin
        inter_q  <= prod_q[INTER_W-1:0];
        uni_q    <= uni[MB_W-1:0];
        nonpos_q <= (uni <= 0);
      end
      P_MUL2: prod_q <= mul_p;
      default: begin
      end
    endcase
  end

  // inter * 65536 > threshold * union, never when the union is not positive
  assign res_o.done     = (state_q == P_CMP);
  assign res_o.suppress = !nonpos_q && (PROD_W'({inter_q, 16'd0}) > prod_q);

endmodule

`default_nettype wire

@@ hdl/greedy_box_suppression_unit.sv @@
// greedy_box_suppression_unit: top level with the suppression sequencer, box,
// flag and kept-index memories and the result register.
// Depends on gbs_pkg, gbs_ram, gbs_loader and gbs_pair_unit.
// Load: one box per cycle; tready stays high until the box with tlast.
// Run: each visited box is read and, if kept, tested against every later box not yet
//   suppressed (read, start, multiplier pass, union, multiplier pass, compare).
// Emit: each kept index is read only once the result register has emptied, so
//   output stalls hold back the next read.
// Reset clears control state only; flags are cleared as each box is loaded.
`default_nettype none

module greedy_box_suppression_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [gbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [gbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // box_x1, box_y1, box_x2, box_y2
  input  wire logic [gbs_pkg::BOX_W-1:0]        s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // kept_index, kept_rank
  output logic [gbs_pkg::OUT_W-1:0]             m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import gbs_pkg::*;

  seq_state_e state_q, state_d;

  logic [THR_W-1:0]  thr_q;
  logic [KLIM_W-1:0] keep_q;
  logic [KLIM_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [KLIM_W-1:0] kept_q, kept_d;
  logic [KLIM_W-1:0] k_q, k_d;

  logic [BOX_W-1:0]         bi_q;
  logic signed [AREA_W-1:0] ai_q;
  logic                     cap_i;

  logic              out_valid_q;
  logic [KIDX_W-1:0] out_idx_q;
  logic [RANK_W-1:0] out_rank_q;
  logic              out_last_q;
  logic              out_load;

  logic      s_accept;
  logic      full;
  ld_wr_t    ld_wr;
  pair_res_t pair_res;
  logic      pair_start;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] entry_rd;
  logic               flag_rd;
  logic               flag_we;
  logic [ADDR_W-1:0]  flag_waddr;
  logic               flag_wdata;
  logic               kept_we;
  logic [ADDR_W-1:0]  kept_rd;

  logic [BOX_W-1:0]         box_rd;
  logic signed [AREA_W-1:0] area_rd;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q == CNT_W'(MAX_BOXES));
  assign box_rd   = entry_rd[BOX_W-1:0];
  assign area_rd  = entry_rd[ENTRY_W-1:BOX_W];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      keep_q <= KEEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IOU_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_KEEP_LIMIT:    keep_q <= cfg_data_i[KLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage and area
  gbs_loader u_loader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .box_i    (s_axis_tdata),
    .addr_i   (count_q[ADDR_W-1:0]),
    .full_i   (full),
    .wr_o     (ld_wr)
  );

  // box store with area
  gbs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ld_wr.we),
    .waddr_i (ld_wr.addr),
    .wdata_i ({ld_wr.area, ld_wr.box}),
    .raddr_i (rd_addr),
    .rdata_o (entry_rd)
  );

  // suppression flags, zeroed as each box is loaded
  always_comb begin
    if (ld_wr.we) begin
      flag_we    = 1'b1;
      flag_waddr = ld_wr.addr;
      flag_wdata = 1'b0;
    end else begin
      flag_we    = (state_q == S_TEST) && pair_res.done && pair_res.suppress;
      flag_waddr = j_q[ADDR_W-1:0];
      flag_wdata = 1'b1;
    end
  end

  gbs_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (rd_addr),
    .rdata_o (flag_rd)
  );

  // kept indices in keep order
  gbs_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_KEEP)) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (kept_we),
    .waddr_i (kept_q[KADDR_W-1:0]),
    .wdata_i (i_q[ADDR_W-1:0]),
    .raddr_i (k_q[KADDR_W-1:0]),
    .rdata_o (kept_rd)
  );

  // shared overlap test
  gbs_pair_unit u_pair (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pair_start),
    .box_a_i  (bi_q),
    .area_a_i (ai_q),
    .box_b_i  (box_rd),
    .area_b_i (area_rd),
    .thr_i    (thr_q),
    .res_o    (pair_res)
  );

  // sequencer: next state and control
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    lim_d      = lim_q;
    i_d        = i_q;
    j_d        = j_q;
    kept_d     = kept_q;
    k_d        = k_q;
    rd_addr    = j_q[ADDR_W-1:0];
    cap_i      = 1'b0;
    kept_we    = 1'b0;
    pair_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (s_accept) begin
          if (!full) count_d = count_q + CNT_W'(1);
          if (s_axis_tlast) state_d = S_START;
        end
      end
      S_START: begin
        i_d     = '0;
        kept_d  = '0;
        k_d     = '0;
        lim_d   = (keep_q > KEEP_MAX) ? KEEP_MAX : keep_q;
        state_d = S_OUTER;
      end
      S_OUTER: begin
        rd_addr = i_q[ADDR_W-1:0];
        if (i_q < count_q && kept_q < lim_q) begin
          state_d = S_IREAD;
        end else begin
          state_d = S_EREQ;
        end
      end
      S_IREAD: begin
        if (flag_rd) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_OUTER;
        end else begin
          cap_i   = 1'b1;
          kept_we = 1'b1;
          kept_d  = kept_q + KLIM_W'(1);
          j_d     = i_q + CNT_W'(1);
          state_d = S_JREQ;
        end
      end
      S_JREQ: begin
        rd_addr = j_q[ADDR_W-1:0];
        if (j_q < count_q) begin
          state_d = S_JREAD;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_OUTER;
        end
      end
      S_JREAD: begin
        if (flag_rd) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_JREQ;
        end else begin
          pair_start = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        if (pair_res.done) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_JREQ;
        end
      end
      S_EREQ: begin
        if (k_q == kept_q) begin
          count_d = '0;
          state_d = S_LOAD;
        end else if (!out_valid_q) begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        out_load = 1'b1;
        k_d      = k_q + KLIM_W'(1);
        state_d  = S_EREQ;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      lim_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      kept_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lim_q   <= lim_d;
      i_q     <= i_d;
      j_q     <= j_d;
      kept_q  <= kept_d;
      k_q     <= k_d;
    end
  end

  // current kept box
  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      bi_q <= box_rd;
      ai_q <= area_rd;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= KIDX_W'(kept_rd);
      out_rank_q <= RANK_W'(k_q);
      out_last_q <= (k_q + KLIM_W'(1) == kept_q);
    end
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rank_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  a_done_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_res.done |-> (state_q == S_TEST))
    else $error("pair result outside of test state");

  a_keep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IREAD) |-> (kept_q < lim_q))
    else $error("keep limit overrun");

  a_load_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_wr.we |-> (state_q == S_LOAD || state_q == S_START))
    else $error("box store write during run");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("result register overwritten");

endmodule

`default_nettype wire
